// ===== rtl/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg
// Types and constants shared by the delayed-off relay timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

  localparam int MINUTES_W   = 13;
  localparam int LONG_W      = 16;
  localparam int BONUS_W     = 8;
  localparam int WINDOW_W    = 16;
  localparam int STEP_W      = 6;
  localparam int TIME_W      = 32;
  localparam int HOLD_W      = 16;
  localparam int BURST_CNT_W = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_MINUTES      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_MS    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BURST_BONUS      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_PER_PRESS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SECONDS_PER_STEP = 3'd4;

  // Register values after reset.
  localparam logic [MINUTES_W-1:0] RST_MAX_MINUTES      = 13'd5999;
  localparam logic [LONG_W-1:0]    RST_LONG_PRESS_MS    = 16'd1000;
  localparam logic [BONUS_W-1:0]   RST_BURST_BONUS      = 8'd10;
  localparam logic [WINDOW_W-1:0]  RST_WINDOW_PER_PRESS = 16'd500;
  localparam logic [STEP_W-1:0]    RST_SECONDS_PER_STEP = 6'd60;

  // Item kinds carried in the input tuser bit.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_PRESS = 1'b1;

  typedef struct packed {
    logic [MINUTES_W-1:0] max_minutes;
    logic [LONG_W-1:0]    long_press_ms;
    logic [BONUS_W-1:0]   burst_bonus;
    logic [WINDOW_W-1:0]  window_per_press_ms;
    logic [STEP_W-1:0]    seconds_per_step;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_ms;
    logic [HOLD_W-1:0] hold_ms;
  } item_t;

  typedef struct packed {
    logic                 relay_on;
    logic [MINUTES_W-1:0] minutes_left;
    logic                 expired;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/drt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// drt_cfg_regs
// Configuration register file written through the index/data port.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_cfg_regs (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [drt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire [drt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output drt_pkg::cfg_t                    cfg
);
  import drt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_MINUTES:      cfg_nxt.max_minutes         = cfg_data[MINUTES_W-1:0];
        REG_LONG_PRESS_MS:    cfg_nxt.long_press_ms       = cfg_data[LONG_W-1:0];
        REG_BURST_BONUS:      cfg_nxt.burst_bonus         = cfg_data[BONUS_W-1:0];
        REG_WINDOW_PER_PRESS: cfg_nxt.window_per_press_ms = cfg_data[WINDOW_W-1:0];
        REG_SECONDS_PER_STEP: cfg_nxt.seconds_per_step    = cfg_data[STEP_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_minutes         <= RST_MAX_MINUTES;
      cfg_r.long_press_ms       <= RST_LONG_PRESS_MS;
      cfg_r.burst_bonus         <= RST_BURST_BONUS;
      cfg_r.window_per_press_ms <= RST_WINDOW_PER_PRESS;
      cfg_r.seconds_per_step    <= RST_SECONDS_PER_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/drt_core.sv =====
// ----------------------------------------------------------------------------
// drt_core
// Timer state registers and the single-pass update for one tick or press.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_core #(
  parameter int BURST_PRESSES = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step_en,
  input  wire drt_pkg::cfg_t    cfg,
  input  wire drt_pkg::item_t   item,
  output drt_pkg::result_t      res
);
  import drt_pkg::*;

  localparam int WIN_FULL_W = WINDOW_W + BURST_CNT_W;
  localparam logic [BURST_CNT_W-1:0] BURST_LAST = BURST_CNT_W'(BURST_PRESSES - 1);
  localparam logic [WIN_FULL_W-1:0]  BURST_LEN  = WIN_FULL_W'(BURST_PRESSES);

  logic [MINUTES_W-1:0]   minutes_r,    minutes_nxt;
  logic                   on_r,         on_nxt;
  logic                   after_long_r, after_long_nxt;
  logic [BURST_CNT_W-1:0] burst_cnt_r,  burst_cnt_nxt;
  logic [TIME_W-1:0]      burst_start_r, burst_start_nxt;
  logic [STEP_W-1:0]      sec_cnt_r,    sec_cnt_nxt;

  logic [WIN_FULL_W-1:0]  window;
  logic [TIME_W-1:0]      elapsed;
  logic [MINUTES_W:0]     bonus_sum;
  logic [MINUTES_W-1:0]   min_bonus;
  logic [STEP_W-1:0]      sec_inc;
  logic [MINUTES_W-1:0]   min_tick;
  logic                   expired;

  always_comb begin
    window    = {{BURST_CNT_W{1'b0}}, cfg.window_per_press_ms} * BURST_LEN;
    elapsed   = item.now_ms - burst_start_r;
    bonus_sum = {1'b0, minutes_r} + {{(MINUTES_W + 1 - BONUS_W){1'b0}}, cfg.burst_bonus};
    sec_inc   = sec_cnt_r + 1'b1;

    minutes_nxt     = minutes_r;
    on_nxt          = on_r;
    after_long_nxt  = after_long_r;
    burst_cnt_nxt   = burst_cnt_r;
    burst_start_nxt = burst_start_r;
    sec_cnt_nxt     = sec_cnt_r;
    min_bonus       = minutes_r;
    min_tick        = minutes_r;
    expired         = 1'b0;

    if (item.func == FUNC_PRESS) begin
      if (item.hold_ms > cfg.long_press_ms) begin
        minutes_nxt    = '0;
        on_nxt         = 1'b0;
        after_long_nxt = 1'b1;
      end else if (after_long_r) begin
        // The first short press after a long one is swallowed.
        after_long_nxt = 1'b0;
      end else begin
        if (burst_cnt_r < BURST_LAST) begin
          if (burst_cnt_r == '0) begin
            burst_start_nxt = item.now_ms;
          end
          burst_cnt_nxt = burst_cnt_r + 1'b1;
        end else begin
          burst_cnt_nxt = '0;
          if (elapsed <= {{(TIME_W - WIN_FULL_W){1'b0}}, window}) begin
            min_bonus = (bonus_sum < {1'b0, cfg.max_minutes}) ?
                        bonus_sum[MINUTES_W-1:0] : cfg.max_minutes;
          end
        end
        minutes_nxt = (min_bonus < cfg.max_minutes) ? min_bonus + 1'b1 : min_bonus;
        on_nxt      = 1'b1;
      end
    end else if (on_r) begin
      sec_cnt_nxt = sec_inc;
      if (sec_inc >= cfg.seconds_per_step) begin
        sec_cnt_nxt = '0;
        if (minutes_r != '0) begin
          min_tick = minutes_r - 1'b1;
        end
      end
      minutes_nxt = min_tick;
      if (min_tick == '0) begin
        on_nxt      = 1'b0;
        sec_cnt_nxt = '0;
        expired     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minutes_r     <= '0;
      on_r          <= 1'b0;
      after_long_r  <= 1'b0;
      burst_cnt_r   <= '0;
      burst_start_r <= '0;
      sec_cnt_r     <= '0;
    end else if (step_en) begin
      minutes_r     <= minutes_nxt;
      on_r          <= on_nxt;
      after_long_r  <= after_long_nxt;
      burst_cnt_r   <= burst_cnt_nxt;
      burst_start_r <= burst_start_nxt;
      sec_cnt_r     <= sec_cnt_nxt;
    end
  end

  assign res.relay_on     = on_nxt;
  assign res.minutes_left = minutes_nxt;
  assign res.expired      = expired;

endmodule

`default_nettype wire

// ===== rtl/delayed_off_relay_timer.sv =====
// ----------------------------------------------------------------------------
// delayed_off_relay_timer
// An accepted beat passes the input register, then the result register, and
// its result then shows on out_tdata. Throughput: one beat per cycle while
// out_tready is not held low; the timer state updates in one pass.
// Reset (rst_n, synchronous): timer state cleared, registers at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_off_relay_timer #(
  parameter int BURST_PRESSES = 4
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // Input stream.
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [47:0]                     in_tdata,  // now_ms[31:0], hold_ms[47:32]
  input  wire                             in_tuser,  // func (0 tick, 1 press)
  // Result stream.
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [15:0]                     out_tdata, // relay_on[0], minutes_left[13:1],
                                                     // expired[14], zero[15]
  // Configuration writes.
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [drt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [drt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import drt_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_v_r;
  result_t step_res;
  result_t out_res_r;
  logic    out_v_r;
  logic    advance;

  assign cfg_ready = 1'b1;

  drt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // The result register moves whenever it is empty or being drained.
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.func    <= in_tuser;
      in_item_r.now_ms  <= in_tdata[TIME_W-1:0];
      in_item_r.hold_ms <= in_tdata[TIME_W+HOLD_W-1:TIME_W];
    end
  end

  drt_core #(
    .BURST_PRESSES (BURST_PRESSES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_v_r && advance),
    .cfg     (cfg),
    .item    (in_item_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_res_r.expired, out_res_r.minutes_left, out_res_r.relay_on};

endmodule

`default_nettype wire

// ===== tb/delayed_off_relay_timer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delayed_off_relay_timer_test
// Self-checking bench for the relay timer. A scoreboard keeps its own copy of
// the timer state and registers, works out the result of every accepted beat
// and compares it field by field with the beats leaving the block. Stimulus is
// a directed run over the corner cases, then random press bursts, tick runs,
// long presses and noise under several register settings and idling patterns.
// ----------------------------------------------------------------------------

module delayed_off_relay_timer_test;
  import drt_pkg::*;

  localparam int BURST_LEN = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENT_ITEMS = 100;

  class relay_timer_scoreboard;
    cfg_t                 regs;
    logic [MINUTES_W-1:0] minutes;
    logic                 relay_on;
    logic                 swallow_next;
    logic [3:0]           burst_count;
    logic [TIME_W-1:0]    burst_start;
    logic [STEP_W-1:0]    second_count;
    result_t              pending_results[$];
    int                   mismatch_count;
    int                   item_count;

    function new();
      regs = '{RST_MAX_MINUTES, RST_LONG_PRESS_MS, RST_BURST_BONUS,
               RST_WINDOW_PER_PRESS, RST_SECONDS_PER_STEP};
      minutes = '0;
      relay_on = 1'b0;
      swallow_next = 1'b0;
      burst_count = '0;
      burst_start = '0;
      second_count = '0;
      mismatch_count = 0;
      item_count = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MAX_MINUTES:      regs.max_minutes = val[MINUTES_W-1:0];
        REG_LONG_PRESS_MS:    regs.long_press_ms = val[LONG_W-1:0];
        REG_BURST_BONUS:      regs.burst_bonus = val[BONUS_W-1:0];
        REG_WINDOW_PER_PRESS: regs.window_per_press_ms = val[WINDOW_W-1:0];
        REG_SECONDS_PER_STEP: regs.seconds_per_step = val[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the timer by one beat and queues the relay state it leaves.
    function void note_item(item_t it);
      result_t     r;
      logic [31:0] elapsed;
      logic [31:0] window;
      logic [31:0] sum;
      r.expired = 1'b0;
      item_count++;
      if (it.func == FUNC_PRESS) begin
        if (it.hold_ms > regs.long_press_ms) begin
          minutes = '0;
          relay_on = 1'b0;
          swallow_next = 1'b1;
        end else if (swallow_next) begin
          swallow_next = 1'b0;
        end else begin
          if (burst_count < 4'(BURST_LEN - 1)) begin
            if (burst_count == 4'd0) burst_start = it.now_ms;
            burst_count = burst_count + 4'd1;
          end else begin
            elapsed = it.now_ms - burst_start;
            window = 32'(regs.window_per_press_ms) * BURST_LEN;
            burst_count = '0;
            if (elapsed <= window) begin
              sum = 32'(minutes) + 32'(regs.burst_bonus);
              minutes = (sum < 32'(regs.max_minutes)) ? sum[MINUTES_W-1:0] : regs.max_minutes;
            end
          end
          if (minutes < regs.max_minutes) minutes = minutes + 1'b1;
          relay_on = 1'b1;
        end
      end else if (relay_on) begin
        second_count = second_count + 1'b1;
        if (second_count >= regs.seconds_per_step) begin
          second_count = '0;
          if (minutes > 0) minutes = minutes - 1'b1;
        end
        if (minutes == 0) begin
          relay_on = 1'b0;
          second_count = '0;
          r.expired = 1'b1;
        end
      end
      r.relay_on = relay_on;
      r.minutes_left = minutes;
      pending_results.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t mismatch (%s): expected relay=%0b min=%0d exp=%0b,",
                 $realtime, what, want.relay_on, want.minutes_left, want.expired,
                 " got relay=%0b min=%0d exp=%0b",
                 got.relay_on, got.minutes_left, got.expired);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("no beat pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.relay_on !== want.relay_on || got.minutes_left !== want.minutes_left ||
            got.expired !== want.expired)
          report("field", want, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata = '0;   // now_ms[31:0], hold_ms[47:32]
  logic                  in_tuser = 1'b0; // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;       // relay_on[0], minutes_left[13:1], expired[14]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  relay_timer_scoreboard sb;
  int                    sender_idle_pct = 0;
  int                    receiver_idle_pct = 0;
  int                    cycle_count = 0;
  logic [31:0]           stamp = '0;

  delayed_off_relay_timer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    item_t   it;
    result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it.func = in_tuser;
        it.now_ms = in_tdata[31:0];
        it.hold_ms = in_tdata[47:32];
        sb.note_item(it);
      end
      if (out_tvalid && out_tready) begin
        got.relay_on = out_tdata[0];
        got.minutes_left = out_tdata[13:1];
        got.expired = out_tdata[14];
        sb.check_result(got);
      end
    end
  end

  // The valid line is left high after a beat; the next call either keeps it
  // high or drops it for a gap, so it never sees two assignments in one step.
  task automatic send_item(logic func, logic [31:0] now_ms, logic [15:0] hold_ms);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {hold_ms, now_ms};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_press(logic [31:0] now_ms, logic [15:0] hold_ms);
    send_item(FUNC_PRESS, now_ms, hold_ms);
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, $urandom(), 16'($urandom_range(65535)));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(cfg_t c);
    logic [CFG_ADDR_W-1:0] addrs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    addrs = '{REG_MAX_MINUTES, REG_LONG_PRESS_MS, REG_BURST_BONUS,
              REG_WINDOW_PER_PRESS, REG_SECONDS_PER_STEP};
    vals = '{16'(c.max_minutes), 16'(c.long_press_ms), 16'(c.burst_bonus),
             16'(c.window_per_press_ms), 16'(c.seconds_per_step)};
    foreach (addrs[i]) begin
      cfg_valid <= 1'b1;
      cfg_addr <= addrs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(addrs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    case ($urandom_range(3))
      0: c.max_minutes = 13'd1;
      1: c.max_minutes = 13'd8191;
      2: c.max_minutes = 13'($urandom_range(2, 12));
      default: c.max_minutes = 13'($urandom_range(1, 8191));
    endcase
    case ($urandom_range(3))
      0: c.long_press_ms = 16'd1;
      1: c.long_press_ms = 16'd65535;
      default: c.long_press_ms = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(2))
      0: c.burst_bonus = 8'd0;
      1: c.burst_bonus = 8'd255;
      default: c.burst_bonus = 8'($urandom_range(255));
    endcase
    case ($urandom_range(3))
      0: c.window_per_press_ms = 16'd1;
      1: c.window_per_press_ms = 16'd65535;
      default: c.window_per_press_ms = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(3))
      0: c.seconds_per_step = 6'd1;
      1: c.seconds_per_step = 6'd63;
      2: c.seconds_per_step = 6'($urandom_range(2, 5));
      default: c.seconds_per_step = 6'($urandom_range(1, 63));
    endcase
    return c;
  endfunction

  function automatic logic [15:0] short_hold(int unsigned limit);
    return 16'($urandom_range(0, limit));
  endfunction

  // With the limit at its top no hold can exceed it, so a short one is used.
  function automatic logic [15:0] long_hold(int unsigned limit);
    if (limit >= 65535) return short_hold(limit);
    return 16'($urandom_range(limit + 1, 65535));
  endfunction

  task automatic run_sequence();
    int unsigned w;
    int unsigned l;
    w = sb.regs.window_per_press_ms;
    l = sb.regs.long_press_ms;
    case ($urandom_range(9))
      0, 1, 2: begin
        repeat (BURST_LEN) begin
          stamp = stamp + $urandom_range(0, w + w / 3);
          send_press(stamp, short_hold(l));
        end
      end
      3, 4, 5: repeat ($urandom_range(1, 70)) send_tick();
      6: begin
        send_press(stamp, long_hold(l));
        stamp = stamp + $urandom_range(0, 4 * w);
        send_press(stamp, short_hold(l));
      end
      7: begin
        stamp = stamp + $urandom_range(0, 8 * w);
        send_press(stamp, short_hold(l));
      end
      default: begin
        stamp = $urandom();
        repeat ($urandom_range(1, 3))
          send_item(1'($urandom_range(1)), $urandom(), 16'($urandom_range(65535)));
      end
    endcase
  endtask

  initial begin
    int goal;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: a tick while off, a burst closing exactly at the
    // window edge, a long press and the press it swallows, then a burst whose
    // timestamps wrap around.
    send_tick();
    send_press(32'd100, 16'd0);
    send_press(32'd200, 16'd1000);
    send_press(32'd300, 16'd1);
    send_press(32'd2100, 16'd500);
    send_press(32'hFFFF_FFFF, 16'hFFFF);
    send_press(32'd0, 16'd5);
    send_press(32'hFFFF_FF00, 16'd0);
    send_press(32'hFFFF_FF80, 16'd0);
    send_press(32'hFFFF_FFFF, 16'd1000);
    send_press(32'h0000_0100, 16'd7);

    // Zero limit and zero step: the press turns the relay on at zero minutes
    // and the next tick switches it off.
    settle();
    load_setting('{13'd0, 16'd1000, 8'd10, 16'd500, 6'd0});
    send_press(32'd5000, 16'd3);
    send_tick();

    // Largest register values, with a bonus burst that lifts the count well
    // above the small limit loaded next.
    settle();
    load_setting('{13'd8191, 16'd65535, 8'd255, 16'd65535, 6'd63});
    repeat (BURST_LEN) send_press(32'd6000, 16'hFFFF);
    settle();
    load_setting('{13'd3, 16'd65535, 8'd255, 16'd65535, 6'd1});
    repeat (BURST_LEN) send_press(32'd6100, 16'd0);
    repeat (3) send_tick();

    goal = sb.item_count;
    for (int seg = 0; seg < 8; seg++) begin
      settle();
      if (seg < 3) begin
        sender_idle_pct = 22;
        receiver_idle_pct = 60;
      end else if (seg < 6) begin
        sender_idle_pct = 60;
        receiver_idle_pct = 22;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      load_setting(random_setting());
      stamp = $urandom();
      goal = goal + SEGMENT_ITEMS;
      while (sb.item_count < goal) run_sequence();
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
